### rtl/wca_pkg.sv
`timescale 1ns / 1ps

package wca_pkg;

    localparam int COORD_W    = 31;
    localparam int DEPTH_W    = 16;
    localparam int LEN_W      = 13;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 80;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd60000;
    localparam logic [LEN_W-1:0]   REGION_LENGTH_RST = 13'd4096;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLIPPED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_RUNS = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] read_start;
        logic [COORD_W-1:0] read_end;
        logic [COORD_W-1:0] query_pos;
    } request_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]  depth;
        logic [COORD_W-1:0]  run_first;
        logic [COORD_W-1:0]  run_last;
        logic [STATUS_W-1:0] status;
        logic                last;
    } result_t;

    function automatic logic [DEPTH_W-1:0] sat_inc(input logic [DEPTH_W-1:0] v);
        return (v < DEPTH_MAX) ? v + 16'd1 : v;
    endfunction

endpackage

### rtl/wca_ram.sv
`timescale 1ns / 1ps

module wca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/wca_seq.sv
`timescale 1ns / 1ps

module wca_seq #(
    parameter int WINDOW_LEN = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  wca_pkg::request_t                    req,
    input  logic [wca_pkg::COORD_W-1:0]          region_start,
    input  logic [$clog2(WINDOW_LEN+1)-1:0]      win_len,
    input  logic                                 out_free,
    output logic                                 res_valid,
    output wca_pkg::result_t                     res,
    output logic                                 ram_wr_en,
    output logic [$clog2(WINDOW_LEN)-1:0]        ram_wr_addr,
    output logic [wca_pkg::DEPTH_W-1:0]          ram_wr_data,
    output logic                                 ram_rd_en,
    output logic [$clog2(WINDOW_LEN)-1:0]        ram_rd_addr,
    input  logic [wca_pkg::DEPTH_W-1:0]          ram_rd_data
);

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int LW = $clog2(WINDOW_LEN + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_LEN - 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DIFF   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_ADD    = 4'd4;
    localparam logic [3:0] S_QRD    = 4'd5;
    localparam logic [3:0] S_RFIRST = 4'd6;
    localparam logic [3:0] S_RUN    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]                   state_reg, state_next;
    wca_pkg::request_t            req_reg, req_next;
    logic [31:0]                  d_rs_reg, d_rs_next;
    logic [31:0]                  d_re_reg, d_re_next;
    logic [31:0]                  d_q_reg, d_q_next;
    logic                         re_ge_rs_reg, re_ge_rs_next;
    logic [LW-1:0]                ptr_reg, ptr_next;
    logic [AW-1:0]                end_reg, end_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [LW-1:0]                pend_idx_reg, pend_idx_next;
    logic                         issuing_reg, issuing_next;
    logic [LW-1:0]                cursor_reg, cursor_next;
    logic [LW-1:0]                run_i_reg, run_i_next;
    logic [wca_pkg::DEPTH_W-1:0]  v_reg, v_next;
    wca_pkg::result_t             res_reg, res_next;
    logic                         clr_cmd_reg, clr_cmd_next;

    logic [31:0]   len32;
    logic [LW-1:0] run_end;
    logic          run_stop;

    assign len32     = 32'(win_len);
    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;

    // a scan stops on a mismatch, or when no read is left in flight (window end)
    assign run_stop = !pend_valid_reg || (ram_rd_data != v_reg);
    assign run_end  = pend_valid_reg ? pend_idx_reg : win_len;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        d_rs_next       = d_rs_reg;
        d_re_next       = d_re_reg;
        d_q_next        = d_q_reg;
        re_ge_rs_next   = re_ge_rs_reg;
        ptr_next        = ptr_reg;
        end_next        = end_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        issuing_next    = issuing_reg;
        cursor_next     = cursor_reg;
        run_i_next      = run_i_reg;
        v_next          = v_reg;
        res_next        = res_reg;
        clr_cmd_next    = clr_cmd_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = ptr_reg[AW-1:0];
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = ptr_reg[AW-1:0];

        unique case (state_reg)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                cursor_next = '0;
                if (ptr_reg[AW-1:0] == LAST_ADDR) begin
                    ptr_next     = '0;
                    clr_cmd_next = 1'b0;
                    state_next   = clr_cmd_reg ? S_OUT : S_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (req_valid) begin
                    req_next   = req;
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                d_rs_next     = {1'b0, req_reg.read_start} - {1'b0, region_start};
                d_re_next     = {1'b0, req_reg.read_end} - {1'b0, region_start};
                d_q_next      = {1'b0, req_reg.query_pos} - {1'b0, region_start};
                re_ge_rs_next = (req_reg.read_end >= req_reg.read_start);
                res_next      = '0;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                unique case (req_reg.cmd)
                    wca_pkg::CMD_ADD: begin
                        if (d_rs_reg[31] || d_rs_reg >= len32) begin
                            res_next.status = wca_pkg::ST_OUTSIDE;
                            state_next      = S_OUT;
                        end else if (!re_ge_rs_reg) begin
                            state_next = S_OUT;
                        end else begin
                            ptr_next        = LW'(d_rs_reg);
                            issuing_next    = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = S_ADD;
                            if (d_re_reg >= len32) begin
                                end_next        = AW'(len32 - 32'd1);
                                res_next.status = wca_pkg::ST_CLIPPED;
                            end else begin
                                end_next = AW'(d_re_reg);
                            end
                        end
                    end
                    wca_pkg::CMD_QUERY: begin
                        if (d_q_reg[31] || d_q_reg >= len32) begin
                            res_next.status = wca_pkg::ST_OUTSIDE;
                            state_next      = S_OUT;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = AW'(d_q_reg);
                            state_next  = S_QRD;
                        end
                    end
                    wca_pkg::CMD_RUN: begin
                        if (cursor_reg >= win_len) begin
                            res_next.status = wca_pkg::ST_NO_RUNS;
                            cursor_next     = '0;
                            state_next      = S_OUT;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = cursor_reg[AW-1:0];
                            run_i_next  = cursor_reg;
                            ptr_next    = cursor_reg + 1'b1;
                            state_next  = S_RFIRST;
                        end
                    end
                    wca_pkg::CMD_CLEAR: begin
                        clr_cmd_next = 1'b1;
                        ptr_next     = '0;
                        state_next   = S_CLEAR;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_ADD: begin
                // read of ptr overlaps write-back of the previous position
                if (issuing_reg) begin
                    ram_rd_en     = 1'b1;
                    pend_idx_next = ptr_reg;
                    if (ptr_reg[AW-1:0] == end_reg) begin
                        issuing_next = 1'b0;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                pend_valid_next = issuing_reg;
                if (pend_valid_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = pend_idx_reg[AW-1:0];
                    ram_wr_data = wca_pkg::sat_inc(ram_rd_data);
                    if (!issuing_reg) begin
                        state_next = S_OUT;
                    end
                end
            end
            S_QRD: begin
                res_next.depth = ram_rd_data;
                state_next     = S_OUT;
            end
            S_RFIRST: begin
                v_next     = ram_rd_data;
                state_next = S_RUN;
                if (ptr_reg < win_len) begin
                    ram_rd_en       = 1'b1;
                    pend_idx_next   = ptr_reg;
                    pend_valid_next = 1'b1;
                    ptr_next        = ptr_reg + 1'b1;
                end else begin
                    pend_valid_next = 1'b0;
                end
            end
            S_RUN: begin
                if (run_stop) begin
                    res_next.depth     = v_reg;
                    res_next.run_first = region_start + wca_pkg::COORD_W'(run_i_reg);
                    res_next.run_last  = region_start
                                         + wca_pkg::COORD_W'(run_end - 1'b1);
                    res_next.last      = (run_end == win_len);
                    cursor_next        = (run_end == win_len) ? '0 : run_end;
                    pend_valid_next    = 1'b0;
                    state_next         = S_OUT;
                end else if (ptr_reg < win_len) begin
                    ram_rd_en       = 1'b1;
                    pend_idx_next   = ptr_reg;
                    pend_valid_next = 1'b1;
                    ptr_next        = ptr_reg + 1'b1;
                end else begin
                    pend_valid_next = 1'b0;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            issuing_reg    <= 1'b0;
            cursor_reg     <= '0;
            clr_cmd_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            issuing_reg    <= issuing_next;
            cursor_reg     <= cursor_next;
            clr_cmd_reg    <= clr_cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        d_rs_reg     <= d_rs_next;
        d_re_reg     <= d_re_next;
        d_q_reg      <= d_q_next;
        re_ge_rs_reg <= re_ge_rs_next;
        end_reg      <= end_next;
        pend_idx_reg <= pend_idx_next;
        run_i_reg    <= run_i_next;
        v_reg        <= v_next;
        res_reg      <= res_next;
    end

endmodule

### rtl/window_coverage_accumulator_core.sv
`timescale 1ns / 1ps

// Read coverage accumulator over one window of up to WINDOW_LEN positions.
// s_ channel: one command per item, kind in s_tuser (add read, query,
//   next run, clear). m_ channel: exactly one result per command, status
//   in m_tuser, m_tlast marks the run that ends the window.
// cfg_ channel: region_start (index 0) and region_length (index 1), always
//   ready; write only while no command is in flight.
// Depth counters live in a single RAM with a registered read.
// Work per command (accept to result loaded):
//   add read : one read-modify-write per covered position (one per cycle,
//              read of the next counter overlaps write-back of the last);
//              no counter is touched when the read is skipped or reversed
//   query    : one counter read (none outside the window)
//   next run : one counter compared per cycle along the run
//   clear    : every RAM entry zeroed, one per cycle
// The next command is taken only from the idle state.
// Reset: a clearing pass zeroes every RAM entry; s_tready stays
//   low until it ends. Config writes are taken during it.
// The result sits in an output register; a new command is taken while it
//   waits, but the next result waits for m_tready before it is loaded.
module window_coverage_accumulator_core #(
    parameter int WINDOW_LEN = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // read_start[30:0], read_end[61:31], query_pos[92:62], zero [95:93]
    input  logic [wca_pkg::S_TDATA_W-1:0]     s_tdata,
    // cmd[1:0]
    input  logic [wca_pkg::CMD_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // depth[15:0], run_first[46:16], run_last[77:47], zero [79:78]
    output logic [wca_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [wca_pkg::STATUS_W-1:0]      m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wca_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int LW = $clog2(WINDOW_LEN + 1);

    logic [wca_pkg::COORD_W-1:0] region_start_reg;
    logic [wca_pkg::LEN_W-1:0]   region_length_reg;
    logic [LW-1:0]               win_len;
    logic [31:0]                 len32;

    wca_pkg::request_t           req;
    wca_pkg::result_t            res;
    logic                        res_valid;
    logic                        out_free;

    logic                        m_tvalid_reg, m_tvalid_next;
    wca_pkg::result_t            m_res_reg;

    logic                        ram_wr_en;
    logic [AW-1:0]               ram_wr_addr;
    logic [wca_pkg::DEPTH_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [AW-1:0]               ram_rd_addr;
    logic [wca_pkg::DEPTH_W-1:0] ram_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_start_reg  <= '0;
            region_length_reg <= wca_pkg::REGION_LENGTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                wca_pkg::CFG_REGION_START:
                    region_start_reg <= cfg_data[wca_pkg::COORD_W-1:0];
                wca_pkg::CFG_REGION_LENGTH:
                    region_length_reg <= cfg_data[wca_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // length in use, clamped to 1..WINDOW_LEN
    assign len32 = 32'(region_length_reg);
    always_comb begin
        if (len32 == 32'd0) begin
            win_len = LW'(1);
        end else if (len32 > 32'(WINDOW_LEN)) begin
            win_len = LW'(WINDOW_LEN);
        end else begin
            win_len = LW'(len32);
        end
    end

    assign req.cmd        = s_tuser;
    assign req.read_start = s_tdata[30:0];
    assign req.read_end   = s_tdata[61:31];
    assign req.query_pos  = s_tdata[92:62];

    wca_seq #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (s_tvalid),
        .req_ready    (s_tready),
        .req          (req),
        .region_start (region_start_reg),
        .win_len      (win_len),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    wca_ram #(
        .WIDTH (wca_pkg::DEPTH_W),
        .DEPTH (WINDOW_LEN)
    ) u_depth_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_res_reg.run_last, m_res_reg.run_first, m_res_reg.depth};
    assign m_tuser  = m_res_reg.status;
    assign m_tlast  = m_res_reg.last;

endmodule

### rtl/wca_checker.sv
`timescale 1ns / 1ps

module wca_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [wca_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [wca_pkg::STATUS_W-1:0]   m_tuser,
    input logic                           m_tlast
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // one command in flight: no accept in the cycle after an accept
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while busy");

    a_no_runs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == wca_pkg::ST_NO_RUNS |-> m_tdata == '0 && !m_tlast)
        else $error("no-runs result carries data");

    a_last_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == wca_pkg::ST_OK)
        else $error("window-end run with bad status");

endmodule

bind window_coverage_accumulator_core wca_checker u_wca_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
